// ----- hdl/lps_pkg.sv -----
package lps_pkg;

	// motion phase
	typedef enum logic [1:0] {
		PH_IDLE   = 2'd0,
		PH_MOVE_X = 2'd1,
		PH_TURN   = 2'd2,
		PH_MOVE_Y = 2'd3
	} phase_t;

	// motor drive code
	typedef enum logic [1:0] {
		DRV_STOP = 2'd0,
		DRV_FWD  = 2'd1,
		DRV_REV  = 2'd2
	} drive_t;

	// event kind
	typedef enum logic [1:0] {
		FN_TICK   = 2'd0,
		FN_RIGHT  = 2'd1,
		FN_LEFT   = 2'd2,
		FN_TARGET = 2'd3
	} func_t;

	// configuration register indexes
	localparam logic CFG_CM_PER_PULSE = 1'b0;
	localparam logic CFG_TURN_MS      = 1'b1;

	localparam logic [7:0]  CPP_RESET  = 8'd69;
	localparam logic [15:0] TURN_RESET = 16'd550;

	// goal in cm against travel in hundredths: both wheels summed, so 2 * 100
	localparam int LEG_SCALE = 200;

	// width of the count fields on the result word
	localparam int OUT_CNT_W = 24;

	// one event word
	typedef struct packed {
		func_t              func;
		logic signed [15:0] target_x;
		logic signed [15:0] target_y;
	} evt_t;

	// one result word
	typedef struct packed {
		drive_t                 right_drive;
		drive_t                 left_drive;
		phase_t                 phase;
		logic [OUT_CNT_W-1:0]   right_count;
		logic [OUT_CNT_W-1:0]   left_count;
	} res_t;

endpackage

// ----- hdl/l_path_motion_sequencer.sv -----
// channel  | handshake            | payload
// event    | evt_valid, evt_stall | func, target_x, target_y
// result   | res_valid, res_stall | right_drive, left_drive, phase, right_count, left_count
// config   | cfg_we               | cfg_index, cfg_data
//
// one event word in and one result word out per cycle, sustained while the result side is not stalled
// an event passes the event register, then the state update into the result register
// the multiply-compare of the leg check sits between those two registers
// arst_n clears the valid flags and the sequencer state to idle and zero counts, config to 69 and 550
// a stalled result holds the event register; the event channel stalls only when both are full
module l_path_motion_sequencer import lps_pkg::*; #(
	parameter int COUNT_BITS = 24
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        evt_valid,
	output logic        evt_stall,
	input  logic [1:0]  func,
	input  logic [15:0] target_x,
	input  logic [15:0] target_y,
	output logic        res_valid,
	input  logic        res_stall,
	output logic [1:0]  right_drive,
	output logic [1:0]  left_drive,
	output logic [1:0]  phase,
	output logic [23:0] right_count,
	output logic [23:0] left_count,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data
);

	logic        evt_valid_s1;
	evt_t        evt_s1;
	logic        res_valid_q;
	res_t        res_q;
	res_t        res_d;
	logic        advance;
	logic [7:0]  cpp_q;
	logic [15:0] turn_ms_q;

	// event register moves on when the result register is free or being taken
	assign advance   = evt_valid_s1 && (!res_valid_q || !res_stall);
	assign evt_stall = evt_valid_s1 && !advance;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cpp_q     <= CPP_RESET;
			turn_ms_q <= TURN_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_CM_PER_PULSE: cpp_q     <= cfg_data[7:0];
				CFG_TURN_MS:      turn_ms_q <= cfg_data;
			endcase
		end
	end

	// event register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			evt_valid_s1 <= 1'b0;
		end else if (!evt_stall) begin
			evt_valid_s1 <= evt_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (evt_valid && !evt_stall) begin
			evt_s1.func     <= func_t'(func);
			evt_s1.target_x <= target_x;
			evt_s1.target_y <= target_y;
		end
	end

	lps_core #(
		.COUNT_BITS(COUNT_BITS)
	) u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.step_en     (advance),
		.evt         (evt_s1),
		.cm_per_pulse(cpp_q),
		.turn_ms     (turn_ms_q),
		.res         (res_d)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_d;
		end
	end

	assign res_valid   = res_valid_q;
	assign right_drive = res_q.right_drive;
	assign left_drive  = res_q.left_drive;
	assign phase       = res_q.phase;
	assign right_count = res_q.right_count;
	assign left_count  = res_q.left_count;

endmodule

// ----- hdl/lps_core.sv -----
module lps_core import lps_pkg::*; #(
	parameter int COUNT_BITS = 24
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        step_en,
	input  evt_t        evt,
	input  logic [7:0]  cm_per_pulse,
	input  logic [15:0] turn_ms,
	output res_t        res
);

	localparam int PW = (COUNT_BITS + 9 > 23) ? COUNT_BITS + 9 : 23;
	localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

	phase_t                  phase_q;
	logic [COUNT_BITS-1:0]   right_q;
	logic [COUNT_BITS-1:0]   left_q;
	logic signed [15:0]      goal_x_q;
	logic signed [15:0]      goal_y_q;
	logic [15:0]             turn_q;

	// state after the event is applied
	phase_t                  phase_e;
	logic [COUNT_BITS-1:0]   right_e;
	logic [COUNT_BITS-1:0]   left_e;
	logic signed [15:0]      goal_x_e;
	logic signed [15:0]      goal_y_e;
	logic [15:0]             turn_e;

	// state after the phase logic
	phase_t                  phase_d;
	logic [COUNT_BITS-1:0]   right_d;
	logic [COUNT_BITS-1:0]   left_d;
	logic [15:0]             turn_d;
	drive_t                  right_drv;
	drive_t                  left_drv;

	logic signed [15:0]      leg_goal;
	logic [COUNT_BITS:0]     edge_sum;
	logic [PW-1:0]           travel;
	logic [PW-1:0]           reach;
	logic                    leg_done;
	logic [COUNT_BITS+OUT_CNT_W-1:0] right_pad;
	logic [COUNT_BITS+OUT_CNT_W-1:0] left_pad;

	// apply the event
	always_comb begin
		phase_e  = phase_q;
		right_e  = right_q;
		left_e   = left_q;
		goal_x_e = goal_x_q;
		goal_y_e = goal_y_q;
		turn_e   = turn_q;
		unique case (evt.func)
			FN_TICK: begin
				if (phase_q == PH_TURN && turn_q != 16'hFFFF) begin
					turn_e = turn_q + 16'd1;
				end
			end
			FN_RIGHT: begin
				if (right_q != CNT_MAX) begin
					right_e = right_q + COUNT_BITS'(1);
				end
			end
			FN_LEFT: begin
				if (left_q != CNT_MAX) begin
					left_e = left_q + COUNT_BITS'(1);
				end
			end
			FN_TARGET: begin
				goal_x_e = evt.target_x;
				goal_y_e = evt.target_y;
				right_e  = '0;
				left_e   = '0;
				phase_e  = PH_MOVE_X;
			end
		endcase
	end

	// leg distance check, one travel multiplier and one goal scaling shared by both legs
	always_comb begin
		leg_goal = (phase_e == PH_MOVE_Y) ? goal_y_e : goal_x_e;
		edge_sum = {1'b0, right_e} + {1'b0, left_e};
		travel   = PW'(edge_sum) * PW'(cm_per_pulse);
		reach    = PW'(leg_goal[14:0]) * PW'(LEG_SCALE);
		leg_done = leg_goal[15] || (leg_goal == 16'sd0) || (travel >= reach);
	end

	// phase logic, at most one change per event
	always_comb begin
		phase_d   = phase_e;
		right_d   = right_e;
		left_d    = left_e;
		turn_d    = turn_e;
		right_drv = DRV_STOP;
		left_drv  = DRV_STOP;
		unique case (phase_e)
			PH_MOVE_X: begin
				if (leg_done) begin
					right_d = '0;
					left_d  = '0;
					turn_d  = '0;
					phase_d = PH_TURN;
				end else begin
					right_drv = DRV_FWD;
					left_drv  = DRV_FWD;
				end
			end
			PH_TURN: begin
				if (turn_e >= turn_ms) begin
					right_d = '0;
					left_d  = '0;
					phase_d = PH_MOVE_Y;
				end else begin
					right_drv = DRV_FWD;
					left_drv  = DRV_REV;
				end
			end
			PH_MOVE_Y: begin
				if (leg_done) begin
					right_d = '0;
					left_d  = '0;
					phase_d = PH_IDLE;
				end else begin
					right_drv = DRV_FWD;
					left_drv  = DRV_FWD;
				end
			end
			PH_IDLE: begin
			end
		endcase
	end

	// result word, counts shown at the output width
	always_comb begin
		right_pad       = {{OUT_CNT_W{1'b0}}, right_d};
		left_pad        = {{OUT_CNT_W{1'b0}}, left_d};
		res.right_drive = right_drv;
		res.left_drive  = left_drv;
		res.phase       = phase_d;
		res.right_count = right_pad[OUT_CNT_W-1:0];
		res.left_count  = left_pad[OUT_CNT_W-1:0];
	end

	// sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			right_q  <= '0;
			left_q   <= '0;
			goal_x_q <= '0;
			goal_y_q <= '0;
			turn_q   <= '0;
		end else if (step_en) begin
			phase_q  <= phase_d;
			right_q  <= right_d;
			left_q   <= left_d;
			goal_x_q <= goal_x_e;
			goal_y_q <= goal_y_e;
			turn_q   <= turn_d;
		end
	end

endmodule

// ----- hdl/lps_checker.sv -----
module lps_checker import lps_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        evt_stall,
	input logic        res_valid,
	input logic        res_stall,
	input logic [1:0]  right_drive,
	input logic [1:0]  left_drive,
	input logic [1:0]  phase,
	input logic [23:0] right_count,
	input logic [23:0] left_count
);

	// a stalled result word holds
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(right_drive) && $stable(left_drive)
			&& $stable(phase) && $stable(right_count) && $stable(left_count))
		else $error("stalled result word changed");

	// with the result side empty the event side never stalls
	assert property (@(posedge clk) disable iff (!arst_n)
		!res_valid |-> !evt_stall)
		else $error("event stalled with empty result register");

	// reverse drive only on the left wheel while turning
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && left_drive == DRV_REV |-> phase == PH_TURN && right_drive == DRV_FWD)
		else $error("reverse drive outside the turn");

	// idle never drives the motors
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && phase == PH_IDLE |-> right_drive == DRV_STOP && left_drive == DRV_STOP)
		else $error("motor driven while idle");

	// a stop outside idle marks a phase change, which clears the counts
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && phase != PH_IDLE && right_drive == DRV_STOP
			|-> right_count == 24'd0 && left_count == 24'd0)
		else $error("counts not cleared on phase change");

endmodule

bind l_path_motion_sequencer lps_checker u_lps_checker (.*);

// ----- test/tb_l_path_motion_sequencer.sv -----
`timescale 1ns / 1ps

module tb_l_path_motion_sequencer;
	import lps_pkg::*;

	localparam int CNT_W = 24;
	// goal in cm against summed travel of both wheels in hundredths of a cm
	localparam int GOAL_SCALE = 200;
	localparam int BATCH_WAIT = 5000;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        evt_valid;
	logic        evt_stall;
	logic [1:0]  func;
	logic [15:0] target_x;
	logic [15:0] target_y;
	logic        res_valid;
	logic        res_stall;
	logic [1:0]  right_drive;
	logic [1:0]  left_drive;
	logic [1:0]  phase;
	logic [23:0] right_count;
	logic [23:0] left_count;
	logic        cfg_we;
	logic        cfg_index;
	logic [15:0] cfg_data;

	l_path_motion_sequencer uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.evt_valid   (evt_valid),
		.evt_stall   (evt_stall),
		.func        (func),
		.target_x    (target_x),
		.target_y    (target_y),
		.res_valid   (res_valid),
		.res_stall   (res_stall),
		.right_drive (right_drive),
		.left_drive  (left_drive),
		.phase       (phase),
		.right_count (right_count),
		.left_count  (left_count),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	always #6 clk = ~clk;

	// robot state as the block should hold it
	phase_t             bot_phase;
	logic [CNT_W-1:0]   bot_right;
	logic [CNT_W-1:0]   bot_left;
	logic signed [15:0] bot_goal_x;
	logic signed [15:0] bot_goal_y;
	logic [15:0]        bot_turn_ticks;
	logic [7:0]         bot_cpp;
	logic [15:0]        bot_turn_ms;

	// status words still owed by the block, oldest first
	res_t status_q[$];

	int  err_count;
	int  events_sent;
	int  long_events;
	int  status_seen;
	int  paths_done;
	int  turns_done;
	int  settings_used;
	int  holds_done;
	int  burst_left;
	bit  hold_kick;

	typedef struct {
		bit          wr_cfg;
		logic [15:0] cpp_w;
		logic [15:0] turn_w;
		func_t       fn;
		logic [15:0] tx;
		logic [15:0] ty;
		bit          typed;
		res_t        want;
	} dir_row_t;

	dir_row_t dir_rows[22];

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		err_count++;
		if (err_count <= 50)
			$display("%0t mismatch %s: got %0h want %0h", $realtime, what, got, want);
	endtask

	// leg check in exact integers: edges * cm_per_pulse >= 200 * goal
	function automatic bit leg_reached(logic signed [15:0] goal);
		longint unsigned travel;
		if (goal <= 0)
			return 1'b1;
		travel = (longint'(bot_right) + longint'(bot_left)) * longint'(bot_cpp);
		return travel >= longint'(goal) * GOAL_SCALE;
	endfunction

	// apply one event, then at most one phase change
	task automatic advance_robot(func_t fn, logic [15:0] tx, logic [15:0] ty,
			output res_t st);
		drive_t rd;
		drive_t ld;
		rd = DRV_STOP;
		ld = DRV_STOP;
		case (fn)
			FN_TICK: begin
				if (bot_phase == PH_TURN && bot_turn_ticks != 16'hFFFF)
					bot_turn_ticks++;
			end
			FN_RIGHT: begin
				if (bot_right != '1)
					bot_right++;
			end
			FN_LEFT: begin
				if (bot_left != '1)
					bot_left++;
			end
			default: begin
				bot_goal_x = tx;
				bot_goal_y = ty;
				bot_right = '0;
				bot_left = '0;
				bot_phase = PH_MOVE_X;
			end
		endcase
		case (bot_phase)
			PH_MOVE_X: begin
				if (leg_reached(bot_goal_x)) begin
					bot_right = '0;
					bot_left = '0;
					bot_turn_ticks = '0;
					bot_phase = PH_TURN;
				end else begin
					rd = DRV_FWD;
					ld = DRV_FWD;
				end
			end
			PH_TURN: begin
				if (bot_turn_ticks >= bot_turn_ms) begin
					bot_right = '0;
					bot_left = '0;
					bot_phase = PH_MOVE_Y;
					turns_done++;
				end else begin
					rd = DRV_FWD;
					ld = DRV_REV;
				end
			end
			PH_MOVE_Y: begin
				if (leg_reached(bot_goal_y)) begin
					bot_right = '0;
					bot_left = '0;
					bot_phase = PH_IDLE;
					paths_done++;
				end else begin
					rd = DRV_FWD;
					ld = DRV_FWD;
				end
			end
			default: ;
		endcase
		st.right_drive = rd;
		st.left_drive = ld;
		st.phase = bot_phase;
		st.right_count = bot_right[23:0];
		st.left_count = bot_left[23:0];
	endtask

	// offer one event word in bursts with random gaps, wait for acceptance
	task automatic put_event(func_t fn, logic [15:0] tx, logic [15:0] ty,
			bit typed = 1'b0, res_t want = '0);
		int   k;
		int   gap;
		res_t calc;
		if (burst_left == 0) begin
			k = $urandom_range(0, 99);
			gap = (k < 30) ? 0 : (k < 90) ? $urandom_range(1, 4) : $urandom_range(5, 16);
			if (gap > 0) begin
				evt_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 40);
		end
		burst_left--;
		evt_valid <= 1'b1;
		func <= fn;
		target_x <= tx;
		target_y <= ty;
		do @(posedge clk); while (evt_stall !== 1'b0);
		advance_robot(fn, tx, ty, calc);
		status_q.push_back(typed ? want : calc);
		events_sent++;
	endtask

	// stop offering and let every owed status word come back
	task automatic finish_batch();
		int w;
		evt_valid <= 1'b0;
		for (w = 0; w < BATCH_WAIT && status_q.size() > 0; w++)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// write both registers on back to back cycles
	task automatic set_config(logic [15:0] cpp_w, logic [15:0] turn_w);
		cfg_we <= 1'b1;
		cfg_index <= CFG_CM_PER_PULSE;
		cfg_data <= cpp_w;
		@(posedge clk);
		bot_cpp = cpp_w[7:0];
		cfg_index <= CFG_TURN_MS;
		cfg_data <= turn_w;
		@(posedge clk);
		bot_turn_ms = turn_w;
		cfg_we <= 1'b0;
		settings_used++;
	endtask

	// leg lengths: mostly short enough for the random edges to reach, some zero or negative
	function automatic logic [15:0] pick_goal();
		int unsigned k;
		int unsigned top;
		k = $urandom_range(0, 99);
		if (k < 8)
			return 16'(-int'($urandom_range(0, 5)));
		if (k < 13)
			return 16'($urandom);
		top = bot_cpp * 60 / GOAL_SCALE;
		if (top < 1)
			top = 1;
		return 16'($urandom_range(1, top));
	endfunction

	// event mix follows the phase so that paths run to the end
	task automatic pick_event(output func_t fn, output logic [15:0] tx,
			output logic [15:0] ty);
		int    k;
		func_t edge_fn;
		k = $urandom_range(0, 99);
		edge_fn = $urandom_range(0, 1) ? FN_RIGHT : FN_LEFT;
		fn = func_t'($urandom_range(0, 3));
		tx = 16'($urandom);
		ty = 16'($urandom);
		case (bot_phase)
			PH_IDLE: begin
				if (k < 30)
					fn = FN_TARGET;
			end
			PH_TURN: begin
				if (k < 85)
					fn = FN_TICK;
				else if (k < 95)
					fn = edge_fn;
				else if (k < 97)
					fn = FN_TARGET;
			end
			default: begin
				if (k < 82)
					fn = edge_fn;
				else if (k < 90)
					fn = FN_TICK;
				else if (k < 94)
					fn = FN_TARGET;
			end
		endcase
		if (fn == FN_TARGET) begin
			tx = pick_goal();
			ty = pick_goal();
		end
	endtask

	// receiver: runs of free flow, light and heavy stalls, and long hold-offs
	initial begin
		int mode;
		int len;
		int pct;
		res_stall <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_kick || $urandom_range(0, 63) == 0) begin
				hold_kick = 1'b0;
				holds_done++;
				res_stall <= 1'b1;
				repeat ($urandom_range(40, 80)) @(posedge clk);
			end else begin
				mode = $urandom_range(0, 2);
				len = $urandom_range(1, 50);
				pct = (mode == 0) ? 0 : (mode == 1) ? 25 : 75;
				repeat (len) begin
					res_stall <= ($urandom_range(0, 99) < pct);
					@(posedge clk);
				end
			end
		end
	end

	// check each accepted status word against the oldest owed one
	always @(posedge clk) begin
		res_t want;
		if (arst_n === 1'b1 && res_valid === 1'b1 && res_stall === 1'b0) begin
			status_seen++;
			if (status_q.size() == 0) begin
				report_mismatch("status word with nothing owed", {26'd0, phase, left_drive,
					right_drive}, 32'd0);
			end else begin
				want = status_q.pop_front();
				if (right_drive !== want.right_drive)
					report_mismatch("right_drive", right_drive, want.right_drive);
				if (left_drive !== want.left_drive)
					report_mismatch("left_drive", left_drive, want.left_drive);
				if (phase !== want.phase)
					report_mismatch("phase", phase, want.phase);
				if (right_count !== want.right_count)
					report_mismatch("right_count", right_count, want.right_count);
				if (left_count !== want.left_count)
					report_mismatch("left_count", left_count, want.left_count);
			end
		end
	end

	initial begin
		#80_000_000;
		$display("TEST FAILED");
		$finish;
	end

	initial begin
		func_t       fn;
		logic [15:0] tx;
		logic [15:0] ty;
		logic [15:0] cpp_w;
		logic [15:0] turn_w;

		arst_n <= 1'b0;
		evt_valid <= 1'b0;
		func <= FN_TICK;
		target_x <= '0;
		target_y <= '0;
		cfg_we <= 1'b0;
		cfg_index <= CFG_CM_PER_PULSE;
		cfg_data <= '0;

		bot_phase = PH_IDLE;
		bot_right = '0;
		bot_left = '0;
		bot_goal_x = '0;
		bot_goal_y = '0;
		bot_turn_ticks = '0;
		bot_cpp = CPP_RESET;
		bot_turn_ms = TURN_RESET;
		burst_left = 0;

		// directed: reset settings, then cm_per_pulse 0 with a one tick turn,
		// then cm_per_pulse 255 with a zero length turn
		dir_rows = '{
			'{0, 16'h0000, 16'h0000, FN_TICK,   16'h5A5A, 16'hA5A5, 1,
				'{DRV_STOP, DRV_STOP, PH_IDLE,   24'd0, 24'd0}},
			'{0, 16'h0000, 16'h0000, FN_RIGHT,  16'hFFFF, 16'h0000, 1,
				'{DRV_STOP, DRV_STOP, PH_IDLE,   24'd1, 24'd0}},
			'{0, 16'h0000, 16'h0000, FN_LEFT,   16'h0000, 16'hFFFF, 1,
				'{DRV_STOP, DRV_STOP, PH_IDLE,   24'd1, 24'd1}},
			'{0, 16'h0000, 16'h0000, FN_TARGET, 16'h8000, 16'h7FFF, 1,
				'{DRV_STOP, DRV_STOP, PH_TURN,   24'd0, 24'd0}},
			'{0, 16'h0000, 16'h0000, FN_RIGHT,  16'h1234, 16'h4321, 1,
				'{DRV_FWD,  DRV_REV,  PH_TURN,   24'd1, 24'd0}},
			'{0, 16'h0000, 16'h0000, FN_TICK,   16'h0000, 16'h0000, 1,
				'{DRV_FWD,  DRV_REV,  PH_TURN,   24'd1, 24'd0}},
			'{0, 16'h0000, 16'h0000, FN_TARGET, 16'h7FFF, 16'hFFFF, 1,
				'{DRV_FWD,  DRV_FWD,  PH_MOVE_X, 24'd0, 24'd0}},
			'{0, 16'h0000, 16'h0000, FN_LEFT,   16'hFFFF, 16'hFFFF, 1,
				'{DRV_FWD,  DRV_FWD,  PH_MOVE_X, 24'd0, 24'd1}},
			'{0, 16'h0000, 16'h0000, FN_TARGET, 16'h0000, 16'h0000, 1,
				'{DRV_STOP, DRV_STOP, PH_TURN,   24'd0, 24'd0}},
			'{1, 16'hFF00, 16'h0001, FN_TARGET, 16'h0001, 16'hFFFB, 1,
				'{DRV_FWD,  DRV_FWD,  PH_MOVE_X, 24'd0, 24'd0}},
			'{0, 16'h0000, 16'h0000, FN_RIGHT,  16'h0000, 16'h0000, 1,
				'{DRV_FWD,  DRV_FWD,  PH_MOVE_X, 24'd1, 24'd0}},
			'{0, 16'h0000, 16'h0000, FN_TARGET, 16'h0000, 16'h0001, 1,
				'{DRV_STOP, DRV_STOP, PH_TURN,   24'd0, 24'd0}},
			'{0, 16'h0000, 16'h0000, FN_TICK,   16'hFFFF, 16'hFFFF, 1,
				'{DRV_STOP, DRV_STOP, PH_MOVE_Y, 24'd0, 24'd0}},
			'{0, 16'h0000, 16'h0000, FN_LEFT,   16'h0000, 16'h0000, 0,
				'{DRV_STOP, DRV_STOP, PH_IDLE,   24'd0, 24'd0}},
			'{0, 16'h0000, 16'h0000, FN_TARGET, 16'hFFFF, 16'h8000, 1,
				'{DRV_STOP, DRV_STOP, PH_TURN,   24'd0, 24'd0}},
			'{0, 16'h0000, 16'h0000, FN_TICK,   16'h0000, 16'h0000, 1,
				'{DRV_STOP, DRV_STOP, PH_MOVE_Y, 24'd0, 24'd0}},
			'{0, 16'h0000, 16'h0000, FN_TICK,   16'h0000, 16'h0000, 1,
				'{DRV_STOP, DRV_STOP, PH_IDLE,   24'd0, 24'd0}},
			'{1, 16'h00FF, 16'h0000, FN_TARGET, 16'h0001, 16'h0002, 1,
				'{DRV_FWD,  DRV_FWD,  PH_MOVE_X, 24'd0, 24'd0}},
			'{0, 16'h0000, 16'h0000, FN_RIGHT,  16'h0000, 16'h0000, 1,
				'{DRV_STOP, DRV_STOP, PH_TURN,   24'd0, 24'd0}},
			'{0, 16'h0000, 16'h0000, FN_RIGHT,  16'h0000, 16'h0000, 1,
				'{DRV_STOP, DRV_STOP, PH_MOVE_Y, 24'd0, 24'd0}},
			'{0, 16'h0000, 16'h0000, FN_LEFT,   16'h0000, 16'h0000, 0,
				'{DRV_STOP, DRV_STOP, PH_IDLE,   24'd0, 24'd0}},
			'{0, 16'h0000, 16'h0000, FN_LEFT,   16'h0000, 16'h0000, 1,
				'{DRV_STOP, DRV_STOP, PH_IDLE,   24'd0, 24'd0}}
		};

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		foreach (dir_rows[i]) begin
			if (dir_rows[i].wr_cfg) begin
				finish_batch();
				set_config(dir_rows[i].cpp_w, dir_rows[i].turn_w);
			end
			put_event(dir_rows[i].fn, dir_rows[i].tx, dir_rows[i].ty,
				dir_rows[i].typed, dir_rows[i].want);
		end

		// random rounds, each under its own settings
		for (int rnd = 0; rnd < 6; rnd++) begin
			case (rnd)
				0: begin
					cpp_w = 16'h00FF;
					turn_w = 16'd1;
				end
				1: begin
					cpp_w = 16'hAB01;
					turn_w = 16'd0;
				end
				default: begin
					cpp_w = {8'($urandom), 8'($urandom_range(1, 255))};
					turn_w = 16'($urandom_range(0, 40));
				end
			endcase
			finish_batch();
			set_config(cpp_w, turn_w);
			if (rnd == 2)
				hold_kick = 1'b1;
			repeat (210) begin
				pick_event(fn, tx, ty);
				put_event(fn, tx, ty);
			end
		end

		// long turn: zero first leg, then 120 ticks, then a one edge second leg
		finish_batch();
		set_config(16'h00FF, 16'd120);
		long_events = events_sent;
		put_event(FN_TARGET, 16'h0000, 16'h0001);
		for (int i = 0; i < 120; i++) begin
			if (i % 40 == 10)
				put_event(FN_LEFT, 16'($urandom), 16'($urandom));
			put_event(FN_TICK, 16'($urandom), 16'($urandom));
		end
		put_event(FN_RIGHT, 16'($urandom), 16'($urandom));
		long_events = events_sent - long_events;

		finish_batch();
		repeat (8) @(posedge clk);
		if (status_q.size() != 0)
			report_mismatch("status words never returned", status_q.size(), 0);

		$display("covered %0d events (%0d in the long turn), %0d status words, %0d settings",
			events_sent, long_events, status_seen, settings_used);
		$display("%0d turns finished, %0d full L paths, %0d long receiver hold-offs",
			turns_done, paths_done, holds_done);
		if (err_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

// ----- sim.f -----
hdl/lps_pkg.sv
hdl/lps_core.sv
hdl/l_path_motion_sequencer.sv
hdl/lps_checker.sv
test/tb_l_path_motion_sequencer.sv
